[hw/rtl/dpec_pkg.sv]
// Package for the dual path event correlator: item types, register indexes
// and path codes. No dependencies.
package dpec_pkg;

    // Path codes carried in the kind field
    localparam logic KIND_FAST = 1'b0;
    localparam logic KIND_SLOW = 1'b1;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH     = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_FAST_DURATION = 8'd1;

    // Register reset values, 1/16 ms units
    localparam logic [23:0] WINDOW_LENGTH_RST     = 24'd12000;
    localparam logic [23:0] MIN_FAST_DURATION_RST = 24'd8000;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic               kind;
        logic [31:0]        arrival_time;
        logic [23:0]        fast_length;
        logic [31:0]        frame_energy;
        logic signed [15:0] frame_snr;
        logic               over_threshold;
    } evt_item_t;

    typedef struct packed {
        logic [15:0]        marker_count;
        logic [31:0]        marker_time;
        logic [23:0]        marker_length;
        logic [31:0]        peak_energy;
        logic signed [15:0] peak_snr;
        logic               high_confidence;
    } marker_item_t;

    typedef struct packed {
        logic [CFG_INDEX_W-1:0] index;
        logic [23:0]            data;
    } cfg_item_t;

endpackage

[hw/rtl/dpec_stream_if.sv]
// Valid/ready channel interface carrying one payload item per handshake.
// Payload type is supplied by the user, normally from dpec_pkg.
interface dpec_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/dual_path_event_correlator.sv]
// Dual path event correlator: matches fast path detections with slow path
// frames and emits classified markers. Uses dpec_pkg and dpec_stream_if.
// Latency: with no backpressure a marker is valid the cycle after the slow item that closes it.
// Throughput: one item per cycle; a two-entry output buffer (output register plus skid)
// keeps input flowing while one marker waits and stalls input once both entries are full.
// Reset (rst_n low, async) clears state, counters and buffers; registers return to 12000/8000.
module dual_path_event_correlator (
    input  logic          clk,
    input  logic          rst_n,
    dpec_stream_if.sink   evt_in,
    dpec_stream_if.source marker_out,
    dpec_stream_if.sink   cfg
);
    import dpec_pkg::*;

    // Configuration registers
    logic [23:0] window_length_reg;
    logic [23:0] min_fast_duration_reg;

    // Correlation state
    logic               pending_reg, pending_next;
    logic [31:0]        armed_time_reg, armed_time_next;
    logic [23:0]        armed_length_reg, armed_length_next;
    logic               slow_seen_reg, slow_seen_next;
    logic [31:0]        best_energy_reg, best_energy_next;
    logic signed [15:0] best_snr_reg, best_snr_next;
    logic [15:0]        confirmed_count_reg, confirmed_count_next;
    logic [15:0]        fast_only_count_reg, fast_only_count_next;
    logic [15:0]        slow_only_count_reg, slow_only_count_next;

    // Output buffer: output register and skid entry
    marker_item_t out_reg;
    marker_item_t skid_reg;
    logic         out_valid_reg;
    logic         skid_valid_reg;

    evt_item_t    item;
    marker_item_t res;
    logic         res_valid;
    logic         evt_acc;
    logic         out_take;
    logic [31:0]  elapsed;
    logic         window_closed;
    logic         long_fast;
    logic [17:0]  count_sum;

    assign item     = evt_in.data;
    assign evt_acc  = evt_in.valid & evt_in.ready;
    assign out_take = out_valid_reg & marker_out.ready;

    // Accept while the skid entry is free; config always accepted
    assign evt_in.ready     = ~skid_valid_reg;
    assign cfg.ready        = 1'b1;
    assign marker_out.valid = out_valid_reg;
    assign marker_out.data  = out_reg;

    // Signed elapsed time since the fast event; negative never closes
    assign elapsed       = item.arrival_time - armed_time_reg;
    assign window_closed = pending_reg & ~elapsed[31] & (elapsed > {8'd0, window_length_reg});
    assign long_fast     = armed_length_reg >= min_fast_duration_reg;

    assign count_sum = {2'd0, confirmed_count_next} + {2'd0, fast_only_count_next}
                     + {2'd0, slow_only_count_next};

    always_comb
    begin
        pending_next         = pending_reg;
        armed_time_next      = armed_time_reg;
        armed_length_next    = armed_length_reg;
        slow_seen_next       = slow_seen_reg;
        best_energy_next     = best_energy_reg;
        best_snr_next        = best_snr_reg;
        confirmed_count_next = confirmed_count_reg;
        fast_only_count_next = fast_only_count_reg;
        slow_only_count_next = slow_only_count_reg;
        res_valid            = 1'b0;
        res.high_confidence  = 1'b0;

        if (evt_acc)
        begin
            if (item.kind == KIND_FAST)
            begin
                // Arm a fresh window, drop any old one and the peak
                pending_next      = 1'b1;
                armed_time_next   = item.arrival_time;
                armed_length_next = item.fast_length;
                slow_seen_next    = 1'b0;
                best_energy_next  = '0;
                best_snr_next     = '0;
            end
            else
            begin
                if (item.over_threshold)
                begin
                    slow_seen_next = 1'b1;
                    // Ties keep the stored peak
                    if (item.frame_energy > best_energy_reg)
                    begin
                        best_energy_next = item.frame_energy;
                        best_snr_next    = item.frame_snr;
                    end
                end
                if (window_closed)
                begin
                    pending_next = 1'b0;
                    priority if (long_fast && slow_seen_next)
                    begin
                        res_valid            = 1'b1;
                        res.high_confidence  = 1'b1;
                        confirmed_count_next = (confirmed_count_reg == COUNT_MAX) ?
                                               COUNT_MAX : confirmed_count_reg + 16'd1;
                    end
                    else if (long_fast)
                    begin
                        res_valid            = 1'b1;
                        fast_only_count_next = (fast_only_count_reg == COUNT_MAX) ?
                                               COUNT_MAX : fast_only_count_reg + 16'd1;
                    end
                    else if (slow_seen_next)
                    begin
                        res_valid            = 1'b1;
                        slow_only_count_next = (slow_only_count_reg == COUNT_MAX) ?
                                               COUNT_MAX : slow_only_count_reg + 16'd1;
                    end
                    else
                    begin
                        // Neither path: close silently
                        res_valid = 1'b0;
                    end
                end
            end
        end

        res.marker_count  = (count_sum > {2'd0, COUNT_MAX}) ? COUNT_MAX : count_sum[15:0];
        res.marker_time   = armed_time_reg;
        res.marker_length = armed_length_reg;
        res.peak_energy   = best_energy_next;
        res.peak_snr      = best_snr_next;
    end

    // Control state, configuration and correlation state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg     <= WINDOW_LENGTH_RST;
            min_fast_duration_reg <= MIN_FAST_DURATION_RST;
            pending_reg           <= 1'b0;
            armed_time_reg        <= '0;
            armed_length_reg      <= '0;
            slow_seen_reg         <= 1'b0;
            best_energy_reg       <= '0;
            best_snr_reg          <= '0;
            confirmed_count_reg   <= '0;
            fast_only_count_reg   <= '0;
            slow_only_count_reg   <= '0;
            out_valid_reg         <= 1'b0;
            skid_valid_reg        <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.data.index == REG_WINDOW_LENGTH)
                begin
                    window_length_reg <= cfg.data.data;
                end
                else if (cfg.data.index == REG_MIN_FAST_DURATION)
                begin
                    min_fast_duration_reg <= cfg.data.data;
                end
            end

            pending_reg         <= pending_next;
            armed_time_reg      <= armed_time_next;
            armed_length_reg    <= armed_length_next;
            slow_seen_reg       <= slow_seen_next;
            best_energy_reg     <= best_energy_next;
            best_snr_reg        <= best_snr_next;
            confirmed_count_reg <= confirmed_count_next;
            fast_only_count_reg <= fast_only_count_next;
            slow_only_count_reg <= slow_only_count_next;

            // Output buffer occupancy
            if (skid_valid_reg)
            begin
                if (out_take)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (res_valid)
            begin
                if (!out_valid_reg || out_take)
                begin
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output buffer payload
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (res_valid)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_reg <= res;
            end
            else
            begin
                skid_reg <= res;
            end
        end
    end

endmodule
